// ===== hw/rtl/drdt_pkg.sv =====
package drdt_pkg;

  localparam int CH_COUNT  = 2;   // channels present, 1 or 2
  localparam int CH_SLOTS  = 2;   // channel slots decoded by window offset bit 8
  localparam int CH_IDX_W  = 1;

  localparam int DIV_STEPS = 32;  // one dividend bit per step
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [31:0] STEP_RESET = 32'h0004_0000;

  localparam logic [7:0] CR_START     = 8'h01;
  localparam logic [7:0] CR_RUNNING   = 8'h02;
  localparam logic [7:0] CR_UNDERFLOW = 8'h20;

  localparam logic [7:0] OFF_CMPA  = 8'h04;
  localparam logic [7:0] OFF_CMPB  = 8'h08;
  localparam logic [7:0] OFF_CTRL  = 8'h0C;
  localparam logic [7:0] OFF_MODE1 = 8'h0D;
  localparam logic [7:0] OFF_MODE2 = 8'h0E;
  localparam logic [7:0] OFF_MODE3 = 8'h0F;
  localparam logic [7:0] OFF_IOC   = 8'h10;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [32:0] divisor;
  } rem_req_t;

endpackage

// ===== hw/rtl/dual_reload_down_timer.sv =====
// a read, write or no-op beat goes to S_DONE and is registered onto out once out is free
// a tick steps through the channels in S_CHAN; a channel that wraps also waits in S_DIV
//   for the bit-serial 33-bit remainder, one dividend bit a cycle; then on to S_DONE
// one input beat at a time; the next beat is taken while the previous result still
//   waits on out
// reset: synchronous active-low rst_n clears all channel registers, tick_step to 0x40000
module dual_reload_down_timer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // window_offset[8:0], access_bytes[12:9], write_data[44:13]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // read_data[31:0], wake_event[32], underflow_rises[34:33]
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CHAN = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [31:0] tick_step_r;
  logic [31:0] count_r  [drdt_pkg::CH_SLOTS];
  logic [31:0] reload_r [drdt_pkg::CH_SLOTS];
  logic [31:0] cmpa_r   [drdt_pkg::CH_SLOTS];
  logic [31:0] cmpb_r   [drdt_pkg::CH_SLOTS];
  logic [7:0]  ctrl_r   [drdt_pkg::CH_SLOTS];
  logic [7:0]  mode1_r  [drdt_pkg::CH_SLOTS];
  logic [7:0]  mode2_r  [drdt_pkg::CH_SLOTS];
  logic [7:0]  mode3_r  [drdt_pkg::CH_SLOTS];
  logic [7:0]  ioc_r    [drdt_pkg::CH_SLOTS];

  logic [drdt_pkg::CH_IDX_W-1:0] ch_idx_r, ch_idx_nxt;
  logic [31:0] res_rd_r, res_rd_nxt;
  logic [1:0]  res_rises_r, res_rises_nxt;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  drdt_pkg::op_t op;
  logic [8:0]    in_off;
  logic [7:0]    off;
  logic [3:0]    nbytes;
  logic [31:0]   wdata;
  logic          in_fire;
  logic          chan_ok;

  logic [drdt_pkg::CH_IDX_W-1:0] cur_ch;
  logic        last_ch;
  logic [31:0] cur_count, cur_reload;
  logic [7:0]  cur_ctrl;

  logic [31:0] cell_word;
  logic [1:0]  lane;
  logic [31:0] rd_val;
  logic [2:0]  lane_sum;

  drdt_pkg::rem_req_t rem_req;
  logic               rem_done;
  logic [32:0]        rem_val;

  logic        cnt_wr;
  logic [31:0] cnt_wval;
  logic        uf_set;

  assign op      = drdt_pkg::op_t'(in_tuser);
  assign in_off  = in_tdata[8:0];
  assign off     = in_off[7:0];
  assign nbytes  = in_tdata[12:9];
  assign wdata   = in_tdata[44:13];
  assign in_fire = in_tvalid && in_tready;
  assign chan_ok = (32'(in_off[8]) < drdt_pkg::CH_COUNT);

  assign in_tready = (state_r == S_IDLE);

  // one channel read port: the window channel when idle, the tick channel otherwise
  assign cur_ch     = (state_r == S_IDLE) ? in_off[8] : ch_idx_r;
  assign cur_count  = count_r[cur_ch];
  assign cur_reload = reload_r[cur_ch];
  assign cur_ctrl   = ctrl_r[cur_ch];
  assign last_ch    = (ch_idx_r == drdt_pkg::CH_IDX_W'(drdt_pkg::CH_COUNT - 1));

  // register cell and starting lane
  always_comb begin
    lane = off[1:0];
    if (off < drdt_pkg::OFF_CMPA) begin
      cell_word = count_r[cur_ch];
    end else if (off < drdt_pkg::OFF_CMPB) begin
      cell_word = cmpa_r[cur_ch];
    end else if (off < drdt_pkg::OFF_CTRL) begin
      cell_word = cmpb_r[cur_ch];
    end else begin
      lane = 2'd0;
      case (off)
        drdt_pkg::OFF_CTRL:  cell_word = {24'd0, ctrl_r[cur_ch]};
        drdt_pkg::OFF_MODE1: cell_word = {24'd0, mode1_r[cur_ch]};
        drdt_pkg::OFF_MODE2: cell_word = {24'd0, mode2_r[cur_ch]};
        drdt_pkg::OFF_MODE3: cell_word = {24'd0, mode3_r[cur_ch]};
        default:             cell_word = {24'd0, ioc_r[cur_ch]};
      endcase
    end
  end

  always_comb begin
    rd_val   = '0;
    lane_sum = '0;
    for (int i = 0; i < 4; i++) begin
      lane_sum = {1'b0, lane} + 3'(i);
      if ((4'(i) < nbytes) && !lane_sum[2]) begin
        rd_val[8*i +: 8] = cell_word[8*lane_sum[1:0] +: 8];
      end
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_idx_nxt    = ch_idx_r;
    res_rd_nxt    = res_rd_r;
    res_rises_nxt = res_rises_r;
    rem_req       = '0;
    cnt_wr        = 1'b0;
    cnt_wval      = cur_count - tick_step_r;
    uf_set        = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_rd_nxt    = '0;
          res_rises_nxt = '0;
          if (op == drdt_pkg::OP_TICK) begin
            ch_idx_nxt = '0;
            state_nxt  = S_CHAN;
          end else begin
            if ((op == drdt_pkg::OP_READ) && chan_ok) begin
              res_rd_nxt = rd_val;
            end
            state_nxt = S_DONE;
          end
        end
      end
      S_CHAN: begin
        if ((cur_ctrl & drdt_pkg::CR_START) == '0) begin
          state_nxt  = last_ch ? S_DONE : S_CHAN;
          ch_idx_nxt = last_ch ? ch_idx_r : ch_idx_r + 1'b1;
        end else if (cur_count > tick_step_r) begin
          cnt_wr     = 1'b1;
          state_nxt  = last_ch ? S_DONE : S_CHAN;
          ch_idx_nxt = last_ch ? ch_idx_r : ch_idx_r + 1'b1;
        end else begin
          // wrap: new count is reload - ((deficit - 1) mod (reload + 1))
          rem_req.start    = 1'b1;
          rem_req.dividend = tick_step_r - cur_count - 32'd1;
          rem_req.divisor  = {1'b0, cur_reload} + 33'd1;
          state_nxt        = S_DIV;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          cnt_wr   = 1'b1;
          cnt_wval = cur_reload - rem_val[31:0];
          if ((cur_ctrl & drdt_pkg::CR_UNDERFLOW) == '0) begin
            uf_set                  = 1'b1;
            res_rises_nxt[ch_idx_r] = 1'b1;
          end
          state_nxt  = last_ch ? S_DONE : S_CHAN;
          ch_idx_nxt = last_ch ? ch_idx_r : ch_idx_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ch_idx_r <= ch_idx_nxt;
      if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_rd_r    <= res_rd_nxt;
    res_rises_r <= res_rises_nxt;
    if ((state_r == S_DONE) && (!out_valid_r || out_tready)) begin
      out_data_r <= {5'd0, res_rises_r, res_rises_r[0], res_rd_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= drdt_pkg::STEP_RESET;
    end else if (cfg_wr_en) begin
      tick_step_r <= cfg_wr_data;
    end
  end

  // channel registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < drdt_pkg::CH_SLOTS; c++) begin
        count_r[c]  <= '0;
        reload_r[c] <= '0;
        cmpa_r[c]   <= '0;
        cmpb_r[c]   <= '0;
        ctrl_r[c]   <= '0;
        mode1_r[c]  <= '0;
        mode2_r[c]  <= '0;
        mode3_r[c]  <= '0;
        ioc_r[c]    <= '0;
      end
    end else begin
      if (in_fire && (op == drdt_pkg::OP_WRITE) && chan_ok) begin
        if (off < drdt_pkg::OFF_CMPA) begin
          count_r[cur_ch]  <= wdata;
          reload_r[cur_ch] <= wdata;
        end else if (off < drdt_pkg::OFF_CMPB) begin
          cmpa_r[cur_ch] <= wdata;
        end else if (off < drdt_pkg::OFF_CTRL) begin
          cmpb_r[cur_ch] <= wdata;
        end else begin
          case (off)
            drdt_pkg::OFF_CTRL: begin
              ctrl_r[cur_ch] <= (cur_ctrl & wdata[7:0] & drdt_pkg::CR_UNDERFLOW)
                              | (wdata[0] ? (drdt_pkg::CR_START | drdt_pkg::CR_RUNNING)
                                          : 8'd0);
            end
            drdt_pkg::OFF_MODE1: mode1_r[cur_ch] <= wdata[7:0];
            drdt_pkg::OFF_MODE2: mode2_r[cur_ch] <= wdata[7:0];
            drdt_pkg::OFF_MODE3: mode3_r[cur_ch] <= wdata[7:0];
            drdt_pkg::OFF_IOC:   ioc_r[cur_ch]   <= wdata[7:0];
            default: ;
          endcase
        end
      end
      if (cnt_wr) begin
        count_r[cur_ch] <= cnt_wval;
      end
      if (uf_set) begin
        ctrl_r[cur_ch] <= cur_ctrl | drdt_pkg::CR_UNDERFLOW;
      end
    end
  end

  drdt_rem u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (rem_req),
    .done  (rem_done),
    .rem   (rem_val)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_DIV))
    else $error("remainder finished outside divide state");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_done && (state_r == S_DIV)) |-> (rem_val <= {1'b0, cur_reload}))
    else $error("remainder not below period");

  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("second beat taken while busy");

  a_wake_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[32] == out_tdata[33]))
    else $error("wake flag differs from channel 0 rise");

  a_tick_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[34:33] != 2'b00)) |-> (out_tdata[31:0] == 32'd0))
    else $error("tick result carries read data");

endmodule

// ===== hw/rtl/drdt_rem.sv =====
module drdt_rem (
  input  logic               clk,
  input  logic               rst_n,
  input  drdt_pkg::rem_req_t req,
  output logic               done,
  output logic [32:0]        rem
);

  logic                           busy_r;
  logic [drdt_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [31:0]                    dvd_r;
  logic [32:0]                    div_r;
  logic [32:0]                    rem_r;

  logic [33:0] shifted;
  logic [34:0] diff;

  // restoring step: bring in the next dividend bit, subtract when it fits
  assign shifted = {rem_r, dvd_r[31]};
  assign diff    = {1'b0, shifted} - {2'b00, div_r};

  assign done = busy_r && (cnt_r == '0);
  assign rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= drdt_pkg::DIV_CNT_W'(drdt_pkg::DIV_STEPS);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (!diff[34]) begin
        rem_r <= diff[32:0];
      end else begin
        rem_r <= shifted[32:0];
      end
    end
  end

endmodule

// ===== bench/tb_dual_reload_down_timer.sv =====
module tb_dual_reload_down_timer;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] rd;
    logic        wake;
    logic [1:0]  rises;
  } timer_result_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata    = '0;
  logic [1:0]  in_tuser    = drdt_pkg::OP_NOP;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;
  logic        cfg_wr_en   = 1'b0;
  logic [31:0] cfg_wr_data = '0;

  // predicted register file
  logic [31:0] m_step = drdt_pkg::STEP_RESET;
  logic [31:0] m_count [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [31:0] m_reload[drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [31:0] m_cmpa  [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [31:0] m_cmpb  [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [7:0]  m_ctrl  [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [7:0]  m_mode1 [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [7:0]  m_mode2 [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [7:0]  m_mode3 [drdt_pkg::CH_SLOTS] = '{default: '0};
  logic [7:0]  m_ioc   [drdt_pkg::CH_SLOTS] = '{default: '0};

  timer_result_t pending_results[$];
  timer_result_t want;
  int fail_count    = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  dual_reload_down_timer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] read_window(int ch, logic [7:0] off, logic [3:0] nbytes);
    logic [31:0] cell_word;
    logic [31:0] v;
    int lane;
    v = '0;
    lane = 0;
    if (off < drdt_pkg::OFF_CMPA) cell_word = m_count[ch];
    else if (off < drdt_pkg::OFF_CMPB) cell_word = m_cmpa[ch];
    else if (off < drdt_pkg::OFF_CTRL) cell_word = m_cmpb[ch];
    else if (off == drdt_pkg::OFF_CTRL) cell_word = {24'h0, m_ctrl[ch]};
    else if (off == drdt_pkg::OFF_MODE1) cell_word = {24'h0, m_mode1[ch]};
    else if (off == drdt_pkg::OFF_MODE2) cell_word = {24'h0, m_mode2[ch]};
    else if (off == drdt_pkg::OFF_MODE3) cell_word = {24'h0, m_mode3[ch]};
    else cell_word = {24'h0, m_ioc[ch]};  // unmapped reads alias io control
    if (off < drdt_pkg::OFF_CTRL) lane = int'(off[1:0]);
    for (int i = 0; i < 4; i++) begin
      if (i < int'(nbytes) && lane + i < 4) v[8*i +: 8] = cell_word[8*(lane+i) +: 8];
    end
    return v;
  endfunction

  function automatic void write_window(int ch, logic [7:0] off, logic [31:0] data);
    logic [7:0] b;
    logic [7:0] keep;
    logic [7:0] start;
    b = data[7:0];
    if (off < drdt_pkg::OFF_CMPA) begin
      m_count[ch] = data;
      m_reload[ch] = data;
    end else if (off < drdt_pkg::OFF_CMPB) begin
      m_cmpa[ch] = data;
    end else if (off < drdt_pkg::OFF_CTRL) begin
      m_cmpb[ch] = data;
    end else if (off == drdt_pkg::OFF_CTRL) begin
      keep = m_ctrl[ch] & b & drdt_pkg::CR_UNDERFLOW;
      start = b & drdt_pkg::CR_START;
      m_ctrl[ch] = start | ((start != 8'h00) ? drdt_pkg::CR_RUNNING : 8'h00) | keep;
    end else if (off == drdt_pkg::OFF_MODE1) begin
      m_mode1[ch] = b;
    end else if (off == drdt_pkg::OFF_MODE2) begin
      m_mode2[ch] = b;
    end else if (off == drdt_pkg::OFF_MODE3) begin
      m_mode3[ch] = b;
    end else if (off == drdt_pkg::OFF_IOC) begin
      m_ioc[ch] = b;
    end
  endfunction

  // returns 1 when the underflow flag rises
  function automatic logic tick_channel(int c);
    logic [63:0] span;
    logic [63:0] rem;
    logic [31:0] deficit_m1;
    if ((m_ctrl[c] & drdt_pkg::CR_START) == 8'h00) return 1'b0;
    if (m_count[c] > m_step) begin
      m_count[c] = m_count[c] - m_step;
      return 1'b0;
    end
    span = {32'h0, m_reload[c]} + 64'd1;
    deficit_m1 = m_step - m_count[c] - 32'd1;  // wraps when count equals step
    rem = {32'h0, deficit_m1} % span;
    m_count[c] = m_reload[c] - rem[31:0];
    if ((m_ctrl[c] & drdt_pkg::CR_UNDERFLOW) == 8'h00) begin
      m_ctrl[c] = m_ctrl[c] | drdt_pkg::CR_UNDERFLOW;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic timer_result_t timer_predict(drdt_pkg::op_t op, logic [8:0] offset,
                                                  logic [3:0] nbytes, logic [31:0] data);
    timer_result_t r;
    int ch;
    r.rd = '0;
    r.wake = 1'b0;
    r.rises = '0;
    ch = int'(offset[8]);
    case (op)
      drdt_pkg::OP_READ: begin
        if (ch < drdt_pkg::CH_COUNT) r.rd = read_window(ch, offset[7:0], nbytes);
      end
      drdt_pkg::OP_WRITE: begin
        if (ch < drdt_pkg::CH_COUNT) write_window(ch, offset[7:0], data);
      end
      drdt_pkg::OP_TICK: begin
        for (int c = 0; c < drdt_pkg::CH_COUNT; c++) r.rises[c] = tick_channel(c);
        r.wake = r.rises[0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_beat(drdt_pkg::op_t op, logic [8:0] offset, logic [3:0] nbytes,
                           logic [31:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {3'b000, data, nbytes, offset};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(timer_predict(op, offset, nbytes, data));
  endtask

  // lower valid and wait until every predicted beat has come out
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_tick_step(logic [31:0] step);
    drain_results();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= step;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    m_step = step;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0:       return 32'd1;
      1:       return 32'hFFFF_FFFF;
      2:       return drdt_pkg::STEP_RESET;
      3:       return $urandom_range(1, 1000);
      4:       return $urandom_range(1, 70000);
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_count();
    case ($urandom_range(5))
      0:       return $urandom();
      1:       return $urandom_range(0, 64);
      2:       return m_step * $urandom_range(1, 8) + $urandom_range(0, 3);
      3:       return 32'hFFFF_FFFF;
      4:       return m_step;
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected out beat, got rd=%h wake=%b rises=%b", $time,
                 out_tdata[31:0], out_tdata[32], out_tdata[34:33]);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[31:0] !== want.rd || out_tdata[32] !== want.wake ||
            out_tdata[34:33] !== want.rises) begin
          fail_count++;
          $display("%0t: expected rd=%h wake=%b rises=%b, got rd=%h wake=%b rises=%b",
                   $time, want.rd, want.wake, want.rises,
                   out_tdata[31:0], out_tdata[32], out_tdata[34:33]);
        end
      end
    end
  end

  task automatic test_reset_values();
    send_beat(drdt_pkg::OP_READ, 9'h000, 4'd4, 32'h0);
    send_beat(drdt_pkg::OP_READ, {1'b1, drdt_pkg::OFF_CTRL}, 4'd1, 32'h0);
    send_beat(drdt_pkg::OP_TICK, 9'h000, 4'd1, 32'h0);  // nothing started yet
  endtask

  task automatic test_register_window();
    send_beat(drdt_pkg::OP_WRITE, 9'h000, 4'd4, 32'hFFFF_FFFF);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_CMPA}, 4'd4, 32'h1234_5678);
    send_beat(drdt_pkg::OP_WRITE, {1'b0, drdt_pkg::OFF_CMPB}, 4'd2, 32'hA5C3_0F96);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_MODE1}, 4'd1, 32'hFFFF_FF81);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_MODE2}, 4'd1, 32'h0000_007E);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_MODE3}, 4'd1, 32'h5555_55AA);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_IOC}, 4'd1, 32'h0000_00FF);
    send_beat(drdt_pkg::OP_WRITE, 9'h1FF, 4'd8, 32'hDEAD_BEEF);  // unmapped, dropped
    send_beat(drdt_pkg::OP_READ, 9'h002, 4'd4, 32'h0);           // lanes past the cell end
    send_beat(drdt_pkg::OP_READ, {1'b1, 8'h05}, 4'd8, 32'h0);
    send_beat(drdt_pkg::OP_READ, 9'h1FF, 4'd4, 32'h0);           // aliases io control
    send_beat(drdt_pkg::OP_READ, {1'b1, drdt_pkg::OFF_MODE1}, 4'd2, 32'h0);
    send_beat(drdt_pkg::OP_NOP, 9'h0AA, 4'd15, 32'hFFFF_FFFF);
  endtask

  task automatic test_zero_step_and_full_reload();
    send_beat(drdt_pkg::OP_WRITE, 9'h000, 4'd4, 32'h0);
    send_beat(drdt_pkg::OP_WRITE, {1'b0, drdt_pkg::OFF_CTRL}, 4'd1, 32'h0000_0001);
    load_tick_step(32'h0);
    send_beat(drdt_pkg::OP_TICK, 9'h000, 4'd1, 32'h0);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, 8'h00}, 4'd4, 32'hFFFF_FFFF);
    send_beat(drdt_pkg::OP_WRITE, {1'b1, drdt_pkg::OFF_CTRL}, 4'd1, 32'h0000_0021);
    load_tick_step(32'hFFFF_FFFF);
    send_beat(drdt_pkg::OP_TICK, 9'h000, 4'd1, 32'h0);  // period of 2^32 on channel 1
    send_beat(drdt_pkg::OP_READ, {1'b1, drdt_pkg::OFF_CTRL}, 4'd1, 32'h0);
    // stop, keep flag
    send_beat(drdt_pkg::OP_WRITE, {1'b0, drdt_pkg::OFF_CTRL}, 4'd1, 32'h0000_00FE);
    send_beat(drdt_pkg::OP_READ, {1'b0, drdt_pkg::OFF_CTRL}, 4'd4, 32'h0);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int pick;
    logic [8:0] offset;
    logic [31:0] data;
    sent = 0;
    while (sent < n_items) begin
      load_tick_step(pick_step());
      for (int c = 0; c < drdt_pkg::CH_COUNT; c++) begin
        send_beat(drdt_pkg::OP_WRITE, {c[0], 8'h00}, 4'd4, pick_count());
        data = $urandom();
        if ($urandom_range(9) != 0) data = data | drdt_pkg::CR_START;
        send_beat(drdt_pkg::OP_WRITE, {c[0], drdt_pkg::OFF_CTRL}, 4'd1, data);
      end
      repeat ($urandom_range(20, 60)) begin
        pick = $urandom_range(99);
        data = $urandom();
        if (pick < 50) begin
          send_beat(drdt_pkg::OP_TICK, 9'($urandom_range(511)), 4'($urandom_range(15)),
                    data);
        end else if (pick < 65) begin
          offset = {1'($urandom_range(1)), 8'($urandom_range(0, 16))};
          send_beat(drdt_pkg::OP_READ, offset, 4'($urandom_range(1, 8)), data);
        end else if (pick < 75) begin
          // rearm so the underflow flag can rise again
          if ($urandom_range(3) != 0) data = data & ~32'(drdt_pkg::CR_UNDERFLOW);
          send_beat(drdt_pkg::OP_WRITE, {1'($urandom_range(1)), drdt_pkg::OFF_CTRL}, 4'd1,
                    data | drdt_pkg::CR_START);
        end else if (pick < 82) begin
          send_beat(drdt_pkg::OP_WRITE, {1'($urandom_range(1)), 8'h00}, 4'd4, pick_count());
        end else begin
          send_beat(drdt_pkg::op_t'($urandom_range(3)), 9'($urandom_range(511)),
                    4'($urandom_range(15)), data);
        end
        sent++;
        if ($urandom_range(199) == 0) drain_results();
      end
      sent += 2 * drdt_pkg::CH_COUNT;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 62;
    test_reset_values();
    test_register_window();
    test_zero_step_and_full_reload();
    load_tick_step(32'd1);
    load_tick_step(drdt_pkg::STEP_RESET);

    test_random_traffic(400);
    send_idle_pct = 62;
    recv_idle_pct = 25;
    test_random_traffic(400);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(400);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("dual_reload_down_timer: match");
    end else begin
      $display("dual_reload_down_timer: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("dual_reload_down_timer: mismatch");
    $finish;
  end

endmodule
